// ===== hdl/hdrd_pkg.sv =====
// Package: shared types, codes and the sRGB threshold table for the HDR display converter.
package hdrd_pkg;

    typedef enum logic [1:0] {
        FMT_PASS = 2'd0,
        FMT_SWAP = 2'd1,
        FMT_HALF = 2'd2
    } t_fmt;

    typedef enum logic [2:0] {
        LS_IDLE,
        LS_MUL1,
        LS_MUL2,
        LS_DIV,
        LS_GAM,
        LS_DONE
    } t_lane_state;

    typedef struct packed {
        logic start;
        logic clear;
    } t_lane_ctl;

    localparam logic [18:0] LIN_MAX = 19'h7FFFF;
    localparam logic [63:0] LowDiv  = 64'd32946;
    localparam logic [63:0] HighDiv = 64'd269025;

    typedef logic [32:0] t_thr_tab [256];

    function automatic logic [63:0] f_q32_mul(logic [63:0] a, logic [63:0] b);
        logic [63:0] p;
        p = a * b;
        return p >> 32;
    endfunction

    function automatic logic [63:0] f_pow5(logic [63:0] r);
        logic [63:0] r2;
        logic [63:0] r4;
        r2 = f_q32_mul(r, r);
        r4 = f_q32_mul(r2, r2);
        return f_q32_mul(r4, r);
    endfunction

    function automatic logic [63:0] f_threshold(logic [63:0] v);
        logic [63:0] s;
        logic [63:0] s2;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        if (v <= 64'd10) begin
            return ((v * 64'd10) << 32) / LowDiv;
        end
        if (v >= 64'd255) begin
            return 64'd1 << 32;
        end
        s  = ((64'd1000 * v + 64'd14025) << 32) / HighDiv;
        s2 = f_q32_mul(s, s);
        lo = 64'd0;
        hi = 64'hFFFF_FFFF;
        for (int k = 0; k < 40; k++) begin
            if (lo < hi) begin
                mid = lo + ((hi - lo + 64'd1) >> 1);
                if (f_pow5(mid) <= s2) begin
                    lo = mid;
                end else begin
                    hi = mid - 64'd1;
                end
            end
        end
        return f_q32_mul(s2, lo);
    endfunction

    function automatic t_thr_tab f_build_thr();
        t_thr_tab t;
        logic [63:0] w;
        t[0] = 33'd0;
        for (int v = 1; v < 256; v++) begin
            w = f_threshold(64'(v));
            t[v] = w[32:0];
        end
        return t;
    endfunction

    localparam t_thr_tab SRGB_THR = f_build_thr();

endpackage

// ===== hdl/hdrd_in_if.sv =====
// Interface: input pixel channel with four 16-bit channel words.
interface hdrd_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] red_word;
    logic [15:0] green_word;
    logic [15:0] blue_word;
    logic [15:0] alpha_word;

    modport source (output valid, output red_word, output green_word, output blue_word,
                    output alpha_word, input ready);
    modport sink   (input valid, input red_word, input green_word, input blue_word,
                    input alpha_word, output ready);
endinterface

// ===== hdl/hdrd_out_if.sv =====
// Interface: output RGBA8 pixel channel.
interface hdrd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output alpha_out, input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    input alpha_out, output ready);
endinterface

// ===== hdl/hdrd_lane.sv =====
// Colour lane: half decode, ACES fit with serial divider, sRGB search over thresholds.
module hdrd_lane
    import hdrd_pkg::*;
#(
    parameter int GAMMA_TABLE_BITS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_lane_ctl   i_ctl,
    input  logic [15:0] i_word,
    output logic        o_done,
    output logic [7:0]  o_value
);

    localparam int GB = GAMMA_TABLE_BITS;

    t_lane_state r_state, n_state;
    logic [18:0] r_lin, n_lin;
    logic        r_zero, n_zero;
    logic        r_sat, n_sat;
    logic [27:0] r_t, n_t;
    logic [27:0] r_u, n_u;
    logic [47:0] r_rem, n_rem;
    logic [47:0] r_den, n_den;
    logic [15:0] r_q, n_q;
    logic [3:0]  r_cnt, n_cnt;
    logic [32:0] r_x, n_x;
    logic [7:0]  r_g, n_g;

    logic [4:0]  dec_e;
    logic [9:0]  dec_m;
    logic [18:0] dec_lin;
    logic        dec_zero;
    logic [47:0] num, den, rs;
    logic [7:0]  cand;
    logic [GB:0] xidx;

    always_comb begin
        dec_e    = i_word[14:10];
        dec_m    = i_word[9:0];
        dec_zero = i_word[15] || (dec_e == 5'd31 && dec_m != 10'd0);
        if (dec_e >= 5'd18) begin
            dec_lin = LIN_MAX;
        end else if (dec_e == 5'd0) begin
            dec_lin = 19'(dec_m >> 8);
        end else if (dec_e >= 5'd9) begin
            dec_lin = 19'({8'd0, 1'b1, dec_m} << (dec_e - 5'd9));
        end else begin
            dec_lin = 19'({1'b1, dec_m} >> (5'd9 - dec_e));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= LS_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_lin  <= n_lin;
        r_zero <= n_zero;
        r_sat  <= n_sat;
        r_t    <= n_t;
        r_u    <= n_u;
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_q    <= n_q;
        r_cnt  <= n_cnt;
        r_x    <= n_x;
        r_g    <= n_g;
    end

    always_comb begin
        n_state = r_state;
        n_lin   = r_lin;
        n_zero  = r_zero;
        n_sat   = r_sat;
        n_t     = r_t;
        n_u     = r_u;
        n_rem   = r_rem;
        n_den   = r_den;
        n_q     = r_q;
        n_cnt   = r_cnt;
        n_x     = r_x;
        n_g     = r_g;
        num     = 48'(r_lin) * 48'(r_t);
        den     = 48'(r_lin) * 48'(r_u) + (48'd14 << 32);
        rs      = {r_rem[46:0], 1'b0};
        cand    = r_g | (8'h80 >> r_cnt[2:0]);
        xidx    = '0;
        unique case (r_state)
            LS_IDLE: begin
                if (i_ctl.start) begin
                    n_lin   = dec_lin;
                    n_zero  = dec_zero;
                    n_state = LS_MUL1;
                end
            end
            LS_MUL1: begin
                n_t     = 28'(28'd251 * 28'(r_lin)) + (28'd3 << 16);
                n_u     = 28'(28'd243 * 28'(r_lin)) + (28'd59 << 16);
                n_state = LS_MUL2;
            end
            LS_MUL2: begin
                n_sat   = (num >= den);
                n_rem   = num;
                n_den   = den;
                n_q     = '0;
                n_cnt   = '0;
                n_state = LS_DIV;
            end
            LS_DIV: begin
                if (rs >= r_den) begin
                    n_rem = rs - r_den;
                    n_q   = {r_q[14:0], 1'b1};
                end else begin
                    n_rem = rs;
                    n_q   = {r_q[14:0], 1'b0};
                end
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    xidx    = {n_q[15 -: GB], 1'b1};
                    n_x     = 33'(xidx) << (31 - GB);
                    n_g     = '0;
                    n_cnt   = '0;
                    n_state = LS_GAM;
                end
            end
            LS_GAM: begin
                if (SRGB_THR[cand] <= r_x) begin
                    n_g = cand;
                end
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'd7) begin
                    n_state = LS_DONE;
                end
            end
            LS_DONE: begin
                if (i_ctl.clear) begin
                    n_state = LS_IDLE;
                end
            end
            default: n_state = LS_IDLE;
        endcase
    end

    assign o_done  = (r_state == LS_DONE);
    assign o_value = r_zero ? 8'd0 : (r_sat ? 8'd255 : r_g);

endmodule

// ===== hdl/hdr_half_to_display_rgba8_unit.sv =====
// Top level: HDR half / byte pixel to RGBA8 display converter.
// Usage:
//   i_pix carries one pixel per transfer (four 16-bit channel words), o_pix
//   returns one RGBA8 pixel per input pixel, in order.
//   i_cfg_we / i_cfg_data write source_format (0 pass, 1 swap red/blue,
//   2 half tonemapped, 3 acts as pass); write only while idle.
//   Every pixel runs through three colour lanes and an alpha path in
//   parallel. Decode happens on the transfer edge; each lane then runs
//   two multiply steps, a 16-step restoring divider and an 8-step gamma
//   search, and the output register is loaded once all three lanes are
//   done. A new pixel is taken only after the last one has been loaded.
//   A finished pixel sits in the output register; the next pixel is taken
//   while it waits. If the receiver stalls, the lanes hold their results
//   and i_pix.ready stays low until the output register frees.
//   Reset clears source_format to pass-through and empties the pipeline.
module hdr_half_to_display_rgba8_unit
    import hdrd_pkg::*;
#(
    parameter int GAMMA_TABLE_BITS = 12
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_data,
    hdrd_in_if.sink    i_pix,
    hdrd_out_if.source o_pix
);

    logic [1:0]  r_src_fmt;
    logic [1:0]  r_fmt;
    logic        r_busy, n_busy;
    logic        r_out_valid, n_out_valid;
    logic [15:0] r_red, r_green, r_blue, r_alpha;
    logic [7:0]  r_ro, r_go, r_bo, r_ao;
    logic [7:0]  n_ro, n_go, n_bo, n_ao;

    t_lane_ctl   ctl;
    logic        take, load;
    logic [2:0]  done;
    logic [7:0]  lane_val [3];
    logic [4:0]  a_e;
    logic [24:0] a_lin;
    logic [32:0] a_prod;
    logic [7:0]  a_val;

    assign take        = i_pix.valid && i_pix.ready;
    assign i_pix.ready = !r_busy;
    assign load        = r_busy && (&done) && (!r_out_valid || o_pix.ready);
    assign ctl.start   = take;
    assign ctl.clear   = load;

    hdrd_lane #(.GAMMA_TABLE_BITS(GAMMA_TABLE_BITS)) u_lane_r (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl), .i_word(i_pix.red_word),
        .o_done(done[0]), .o_value(lane_val[0])
    );
    hdrd_lane #(.GAMMA_TABLE_BITS(GAMMA_TABLE_BITS)) u_lane_g (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl), .i_word(i_pix.green_word),
        .o_done(done[1]), .o_value(lane_val[1])
    );
    hdrd_lane #(.GAMMA_TABLE_BITS(GAMMA_TABLE_BITS)) u_lane_b (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl), .i_word(i_pix.blue_word),
        .o_done(done[2]), .o_value(lane_val[2])
    );

    always_comb begin
        a_e    = r_alpha[14:10];
        a_lin  = '0;
        a_prod = '0;
        if (r_alpha[15]) begin
            a_val = 8'd0;
        end else if (a_e == 5'd31) begin
            a_val = (r_alpha[9:0] != 10'd0) ? 8'd0 : 8'd255;
        end else if (a_e >= 5'd16) begin
            a_val = 8'd255;
        end else begin
            if (a_e == 5'd0) begin
                a_lin = 25'(r_alpha[9:0]);
            end else begin
                a_lin = 25'({1'b1, r_alpha[9:0]}) << (a_e - 5'd1);
            end
            if (a_lin > (25'd1 << 24)) begin
                a_lin = 25'd1 << 24;
            end
            a_prod = 33'(a_lin) * 33'd255;
            a_val  = a_prod[31:24];
        end
    end

    always_comb begin
        n_busy      = r_busy;
        n_out_valid = r_out_valid;
        n_ro        = r_ro;
        n_go        = r_go;
        n_bo        = r_bo;
        n_ao        = r_ao;
        if (r_out_valid && o_pix.ready) begin
            n_out_valid = 1'b0;
        end
        if (take) begin
            n_busy = 1'b1;
        end
        if (load) begin
            n_busy      = 1'b0;
            n_out_valid = 1'b1;
            case (r_fmt)
                FMT_HALF: begin
                    n_ro = lane_val[0];
                    n_go = lane_val[1];
                    n_bo = lane_val[2];
                    n_ao = a_val;
                end
                FMT_SWAP: begin
                    n_ro = r_blue[7:0];
                    n_go = r_green[7:0];
                    n_bo = r_red[7:0];
                    n_ao = r_alpha[7:0];
                end
                default: begin
                    n_ro = r_red[7:0];
                    n_go = r_green[7:0];
                    n_bo = r_blue[7:0];
                    n_ao = r_alpha[7:0];
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_fmt   <= FMT_PASS;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_src_fmt <= i_cfg_data;
            end
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
        if (take) begin
            r_fmt   <= r_src_fmt;
            r_red   <= i_pix.red_word;
            r_green <= i_pix.green_word;
            r_blue  <= i_pix.blue_word;
            r_alpha <= i_pix.alpha_word;
        end
        r_ro <= n_ro;
        r_go <= n_go;
        r_bo <= n_bo;
        r_ao <= n_ao;
    end

    assign o_pix.valid     = r_out_valid;
    assign o_pix.red_out   = r_ro;
    assign o_pix.green_out = r_go;
    assign o_pix.blue_out  = r_bo;
    assign o_pix.alpha_out = r_ao;

endmodule
